// ===== src/fct_pkg.sv =====
// Shared constants for the frustum cull test unit.
// Used by fct_cell and frustum_cull_test_unit; no dependencies.
package fct_pkg;

    localparam int REG_COUNT      = 6;
    localparam int CFG_INDEX_BITS = 3;
    localparam int PLANE_BITS     = 64;
    localparam int CMD_BITS       = 2;

    // command bit roles: bit 1 selects the box test, else bit 0 the sphere test
    localparam int CMD_SPHERE_BIT = 0;
    localparam int CMD_BOX_BIT    = 1;

endpackage

// ===== src/fct_cell.sv =====
// One plane test cell: products in the first stage, plane sum and compare in the second.
// Depends on fct_pkg; instanced in a chain by frustum_cull_test_unit.
module fct_cell
    import fct_pkg::*;
#(
    parameter int POSITION_BITS = 24,
    parameter int NORMAL_BITS   = 12
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [PLANE_BITS-1:0]           plane,
    input  logic                            up_valid,
    output logic                            up_ready,
    input  logic [CMD_BITS-1:0]             up_command,
    input  logic signed [POSITION_BITS-1:0] up_center_x,
    input  logic signed [POSITION_BITS-1:0] up_center_y,
    input  logic signed [POSITION_BITS-1:0] up_center_z,
    input  logic [POSITION_BITS-2:0]        up_sphere_radius,
    input  logic [POSITION_BITS-2:0]        up_box_len_x,
    input  logic [POSITION_BITS-2:0]        up_box_len_y,
    input  logic [POSITION_BITS-2:0]        up_box_len_z,
    input  logic                            up_inside,
    output logic                            dn_valid,
    input  logic                            dn_ready,
    output logic [CMD_BITS-1:0]             dn_command,
    output logic signed [POSITION_BITS-1:0] dn_center_x,
    output logic signed [POSITION_BITS-1:0] dn_center_y,
    output logic signed [POSITION_BITS-1:0] dn_center_z,
    output logic [POSITION_BITS-2:0]        dn_sphere_radius,
    output logic [POSITION_BITS-2:0]        dn_box_len_x,
    output logic [POSITION_BITS-2:0]        dn_box_len_y,
    output logic [POSITION_BITS-2:0]        dn_box_len_z,
    output logic                            dn_inside
);

    localparam int PB  = POSITION_BITS;
    localparam int NB  = NORMAL_BITS;
    localparam int DB  = PLANE_BITS - 3 * NB;
    localparam int NF  = NB - 2;
    localparam int PW  = NB + PB;
    localparam int RW  = NB + PB - 1;
    localparam int VW0 = (PW + 2 > DB + NF) ? PW + 2 : DB + NF;
    localparam int VW  = VW0 + 1;
    localparam int TW  = VW + 2;

    logic signed [NB-1:0] a;
    logic signed [NB-1:0] b;
    logic signed [NB-1:0] c;
    logic signed [DB-1:0] d;
    logic [NB-1:0]        a_abs;
    logic [NB-1:0]        b_abs;
    logic [NB-1:0]        c_abs;

    assign a = plane[NB-1:0];
    assign b = plane[2*NB-1:NB];
    assign c = plane[3*NB-1:2*NB];
    assign d = plane[PLANE_BITS-1:3*NB];

    assign a_abs = a[NB-1] ? NB'(-a) : NB'(a);
    assign b_abs = b[NB-1] ? NB'(-b) : NB'(b);
    assign c_abs = c[NB-1] ? NB'(-c) : NB'(c);

    // stage 1 registers
    logic                 v1_reg;
    logic                 v1_next;
    logic [CMD_BITS-1:0]  cmd1_reg;
    logic signed [PB-1:0] cx1_reg;
    logic signed [PB-1:0] cy1_reg;
    logic signed [PB-1:0] cz1_reg;
    logic [PB-2:0]        r1_reg;
    logic [PB-2:0]        lx1_reg;
    logic [PB-2:0]        ly1_reg;
    logic [PB-2:0]        lz1_reg;
    logic                 in1_reg;
    logic signed [PW-1:0] pax_reg;
    logic signed [PW-1:0] pby_reg;
    logic signed [PW-1:0] pcz_reg;
    logic [RW-1:0]        rax_reg;
    logic [RW-1:0]        rby_reg;
    logic [RW-1:0]        rcz_reg;
    logic signed [PW-1:0] pax_next;
    logic signed [PW-1:0] pby_next;
    logic signed [PW-1:0] pcz_next;
    logic [RW-1:0]        rax_next;
    logic [RW-1:0]        rby_next;
    logic [RW-1:0]        rcz_next;

    // stage 2 registers
    logic                 v2_reg;
    logic                 v2_next;
    logic [CMD_BITS-1:0]  cmd2_reg;
    logic signed [PB-1:0] cx2_reg;
    logic signed [PB-1:0] cy2_reg;
    logic signed [PB-1:0] cz2_reg;
    logic [PB-2:0]        r2_reg;
    logic [PB-2:0]        lx2_reg;
    logic [PB-2:0]        ly2_reg;
    logic [PB-2:0]        lz2_reg;
    logic                 in2_reg;
    logic                 in2_next;

    logic ready1;
    logic ready2;

    assign ready2   = !v2_reg || dn_ready;
    assign ready1   = !v1_reg || ready2;
    assign up_ready = ready1;

    assign v1_next = ready1 ? up_valid : v1_reg;
    assign v2_next = ready2 ? v1_reg : v2_reg;

    assign pax_next = PW'(a) * PW'(up_center_x);
    assign pby_next = PW'(b) * PW'(up_center_y);
    assign pcz_next = PW'(c) * PW'(up_center_z);
    assign rax_next = RW'(a_abs) * RW'(up_box_len_x);
    assign rby_next = RW'(b_abs) * RW'(up_box_len_y);
    assign rcz_next = RW'(c_abs) * RW'(up_box_len_z);

    logic signed [TW-1:0] val;
    logic signed [TW-1:0] reach;
    logic signed [TW-1:0] rscale;
    logic signed [TW-1:0] box_sum;
    logic signed [TW-1:0] sph_sum;
    logic                 fail;

    always_comb
    begin
        val     = TW'(pax_reg) + TW'(pby_reg) + TW'(pcz_reg) + (TW'(d) <<< NF);
        reach   = TW'(rax_reg) + TW'(rby_reg) + TW'(rcz_reg);
        rscale  = TW'(r1_reg) <<< NF;
        box_sum = (val <<< 1) + reach;
        sph_sum = val + rscale;
        if (cmd1_reg[CMD_BOX_BIT])
        begin
            fail = box_sum[TW-1] || (box_sum == '0);
        end
        else if (cmd1_reg[CMD_SPHERE_BIT])
        begin
            fail = sph_sum[TW-1];
        end
        else
        begin
            fail = val[TW-1];
        end
        in2_next = in1_reg && !fail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            cmd1_reg <= up_command;
            cx1_reg  <= up_center_x;
            cy1_reg  <= up_center_y;
            cz1_reg  <= up_center_z;
            r1_reg   <= up_sphere_radius;
            lx1_reg  <= up_box_len_x;
            ly1_reg  <= up_box_len_y;
            lz1_reg  <= up_box_len_z;
            in1_reg  <= up_inside;
            pax_reg  <= pax_next;
            pby_reg  <= pby_next;
            pcz_reg  <= pcz_next;
            rax_reg  <= rax_next;
            rby_reg  <= rby_next;
            rcz_reg  <= rcz_next;
        end
        if (ready2)
        begin
            cmd2_reg <= cmd1_reg;
            cx2_reg  <= cx1_reg;
            cy2_reg  <= cy1_reg;
            cz2_reg  <= cz1_reg;
            r2_reg   <= r1_reg;
            lx2_reg  <= lx1_reg;
            ly2_reg  <= ly1_reg;
            lz2_reg  <= lz1_reg;
            in2_reg  <= in2_next;
        end
    end

    assign dn_valid         = v2_reg;
    assign dn_command       = cmd2_reg;
    assign dn_center_x      = cx2_reg;
    assign dn_center_y      = cy2_reg;
    assign dn_center_z      = cz2_reg;
    assign dn_sphere_radius = r2_reg;
    assign dn_box_len_x     = lx2_reg;
    assign dn_box_len_y     = ly2_reg;
    assign dn_box_len_z     = lz2_reg;
    assign dn_inside        = in2_reg;

    // an item that already failed upstream never comes back inside
    a_fail_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && ready2 && !in1_reg) |=> !in2_reg)
        else $error("failed item turned inside");

    // a held downstream item keeps its verdict
    a_hold_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !dn_ready) |=> (v2_reg && $stable(in2_reg)))
        else $error("held verdict changed");

    // first stage takes nothing new while it is blocked
    a_s1_block: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && !dn_ready) |-> !up_ready)
        else $error("stage 1 open while blocked");

endmodule

// ===== src/frustum_cull_test_unit.sv =====
// Top level of the frustum cull test unit: plane registers and a chain of plane test cells.
// Depends on fct_pkg and fct_cell.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+---------------------------
//  in       | command, center_x/y/z, sphere_radius,     | in_valid / in_stall
//           | box_len_x/y/z                             |
//  out      | inside_res                                | out_valid / out_stall
//  cfg      | cfg_index, cfg_data                       | cfg_valid / cfg_ready
//
// One item per cycle sustained while out_stall is low; each item passes the product and
// compare registers of every cell in the chain, one cell per tested plane.
// Reset clears all plane registers to zero and empties the chain.
// out_stall backs the chain up; empty slots close up, so in_stall rises only
// when every cell holds an item. cfg_ready is always high.
module frustum_cull_test_unit
    import fct_pkg::*;
#(
    parameter int PLANE_COUNT   = 6,
    parameter int POSITION_BITS = 24,
    parameter int NORMAL_BITS   = 12
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [CMD_BITS-1:0]             command,
    input  logic signed [POSITION_BITS-1:0] center_x,
    input  logic signed [POSITION_BITS-1:0] center_y,
    input  logic signed [POSITION_BITS-1:0] center_z,
    input  logic [POSITION_BITS-2:0]        sphere_radius,
    input  logic [POSITION_BITS-2:0]        box_len_x,
    input  logic [POSITION_BITS-2:0]        box_len_y,
    input  logic [POSITION_BITS-2:0]        box_len_z,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            inside_res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [PLANE_BITS-1:0]           cfg_data
);

    localparam int NCELL = (PLANE_COUNT < REG_COUNT) ? PLANE_COUNT : REG_COUNT;
    localparam int PB    = POSITION_BITS;

    logic [REG_COUNT-1:0][PLANE_BITS-1:0] plane_reg;
    logic [REG_COUNT-1:0][PLANE_BITS-1:0] plane_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        plane_next = plane_reg;
        for (int i = 0; i < REG_COUNT; i++)
        begin
            if (cfg_valid && cfg_ready && (cfg_index == CFG_INDEX_BITS'(i)))
            begin
                plane_next[i] = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else
        begin
            plane_reg <= plane_next;
        end
    end

    logic                 ch_valid  [NCELL+1];
    logic                 ch_ready  [NCELL+1];
    logic [CMD_BITS-1:0]  ch_cmd    [NCELL+1];
    logic signed [PB-1:0] ch_cx     [NCELL+1];
    logic signed [PB-1:0] ch_cy     [NCELL+1];
    logic signed [PB-1:0] ch_cz     [NCELL+1];
    logic [PB-2:0]        ch_r      [NCELL+1];
    logic [PB-2:0]        ch_lx     [NCELL+1];
    logic [PB-2:0]        ch_ly     [NCELL+1];
    logic [PB-2:0]        ch_lz     [NCELL+1];
    logic                 ch_inside [NCELL+1];

    assign ch_valid[0]  = in_valid;
    assign in_stall     = !ch_ready[0];
    assign ch_cmd[0]    = command;
    assign ch_cx[0]     = center_x;
    assign ch_cy[0]     = center_y;
    assign ch_cz[0]     = center_z;
    assign ch_r[0]      = sphere_radius;
    assign ch_lx[0]     = box_len_x;
    assign ch_ly[0]     = box_len_y;
    assign ch_lz[0]     = box_len_z;
    assign ch_inside[0] = 1'b1;

    for (genvar g = 0; g < NCELL; g++)
    begin : g_chain
        fct_cell #(
            .POSITION_BITS (POSITION_BITS),
            .NORMAL_BITS   (NORMAL_BITS)
        ) u_cell (
            .clk              (clk),
            .rst_n            (rst_n),
            .plane            (plane_reg[g]),
            .up_valid         (ch_valid[g]),
            .up_ready         (ch_ready[g]),
            .up_command       (ch_cmd[g]),
            .up_center_x      (ch_cx[g]),
            .up_center_y      (ch_cy[g]),
            .up_center_z      (ch_cz[g]),
            .up_sphere_radius (ch_r[g]),
            .up_box_len_x     (ch_lx[g]),
            .up_box_len_y     (ch_ly[g]),
            .up_box_len_z     (ch_lz[g]),
            .up_inside        (ch_inside[g]),
            .dn_valid         (ch_valid[g+1]),
            .dn_ready         (ch_ready[g+1]),
            .dn_command       (ch_cmd[g+1]),
            .dn_center_x      (ch_cx[g+1]),
            .dn_center_y      (ch_cy[g+1]),
            .dn_center_z      (ch_cz[g+1]),
            .dn_sphere_radius (ch_r[g+1]),
            .dn_box_len_x     (ch_lx[g+1]),
            .dn_box_len_y     (ch_ly[g+1]),
            .dn_box_len_z     (ch_lz[g+1]),
            .dn_inside        (ch_inside[g+1])
        );
    end

    assign ch_ready[NCELL] = !out_stall;
    assign out_valid       = ch_valid[NCELL];
    assign inside_res      = ch_inside[NCELL];

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

    a_cfg_ignore: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && (cfg_index >= CFG_INDEX_BITS'(REG_COUNT))) |=> $stable(plane_reg))
        else $error("write beyond register list changed a plane");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_index < CFG_INDEX_BITS'(REG_COUNT)))
        |=> (plane_reg[$past(cfg_index)] == $past(cfg_data)))
        else $error("plane register write lost");

endmodule
